// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge out of reset
`define C14_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed in coefficient pack unpack block");

// expression must never be true out of reset
`define C14_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition in coefficient pack unpack block");

`else

`define C14_ASSERT(label, clk, rst_n, prop)
`define C14_NEVER(label, clk, rst_n, expr)

`endif

`endif

// File: rtl/core/c14pu_pkg.sv
// ----------------------------------------------------------------------------
// c14pu_pkg
// Shared widths, constants and types of the 14-bit coefficient packer.
// ----------------------------------------------------------------------------
package c14pu_pkg;

    // field and state widths
    localparam int WORD_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int COEF_W  = 14;
    localparam int BUF_W   = 30;
    localparam int CNT_W   = 5;
    localparam int GP_W    = 3;

    // default modulus for pack mode reduction
    localparam int MODULUS_DEF = 12289;

    // bit count clamps before appending a new item
    localparam logic [CNT_W-1:0] PACK_CLAMP   = 5'd16;
    localparam logic [CNT_W-1:0] UNPACK_CLAMP = 5'd14;

    // bits added per item and bits taken per result
    localparam logic [CNT_W-1:0] COEF_BITS = 5'd14;
    localparam logic [CNT_W-1:0] WORD_BITS = 5'd16;
    localparam logic [CNT_W-1:0] TWO_COEF_BITS = 5'd28;

    // last slot of a group of eight
    localparam logic [GP_W-1:0] GROUP_LAST = 3'd7;

    // one result item
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
        logic              gend;
    } c14pu_result_t;

endpackage

// File: rtl/core/c14pu_reduce.sv
// ----------------------------------------------------------------------------
// c14pu_reduce
// Three-stage input pipeline: register, reciprocal multiply, residue fix-up.
// Pack mode reduces the word modulo MODULUS; unpack mode passes it through.
// ----------------------------------------------------------------------------
module c14pu_reduce
    import c14pu_pkg::*;
#(
    parameter int MODULUS = MODULUS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pack_mode,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [WORD_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] out_data
);

    // reciprocal scaled by 2^32, quotient estimate is low by at most one
    localparam logic [32:0]       RECIP_NUM = 33'h1_0000_0000;
    localparam logic [31:0]       RECIP     = 32'(RECIP_NUM / MODULUS);
    localparam logic [WORD_W-1:0] MOD_W     = WORD_W'(MODULUS);

    logic              va_reg, vb_reg, vc_reg;
    logic [WORD_W-1:0] wa_reg, wb_reg;
    logic [WORD_W-1:0] qb_reg;
    logic [WORD_W-1:0] dc_reg, dc_next;
    logic              load_a, load_b, load_c;
    logic [47:0]       prod_a;
    logic [31:0]       qm_b;
    logic [WORD_W-1:0] rem_b;

    // stage enables, each stage loads when empty or draining
    assign load_c   = !vc_reg || out_ready;
    assign load_b   = !vb_reg || load_c;
    assign load_a   = !va_reg || load_b;
    assign in_ready = load_a;

    // quotient estimate
    assign prod_a = 48'(wa_reg) * 48'(RECIP);

    // residue with one correction step
    always_comb begin
        qm_b  = 32'(qb_reg) * 32'(MOD_W);
        rem_b = wb_reg - qm_b[WORD_W-1:0];
        if (!pack_mode) begin
            dc_next = wb_reg;
        end else if (rem_b >= MOD_W) begin
            dc_next = rem_b - MOD_W;
        end else begin
            dc_next = rem_b;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            if (load_a) begin
                va_reg <= in_valid;
            end
            if (load_b) begin
                vb_reg <= va_reg;
            end
            if (load_c) begin
                vc_reg <= vb_reg;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load_a && in_valid) begin
            wa_reg <= in_data;
        end
        if (load_b && va_reg) begin
            wb_reg <= wa_reg;
            qb_reg <= prod_a[47:32];
        end
        if (load_c && vb_reg) begin
            dc_reg <= dc_next;
        end
    end

    assign out_valid = vc_reg;
    assign out_data  = dc_reg;

endmodule

// File: rtl/core/c14pu_gearbox.sv
// ----------------------------------------------------------------------------
// c14pu_gearbox
// Bit buffer that turns 14-bit coefficients into 16-bit words and back.
// Gives up to two results per item and updates its state on fire.
// ----------------------------------------------------------------------------
module c14pu_gearbox
    import c14pu_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clear,
    input  logic              fire,
    input  logic              pack_mode,
    input  logic [WORD_W-1:0] item,
    output logic [1:0]        res_count,
    output c14pu_result_t     res0,
    output c14pu_result_t     res1
);

    logic [BUF_W-1:0] buf_reg, buf_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [GP_W-1:0]  gp_reg, gp_next;
    logic [CNT_W-1:0] cnt_clamp;
    logic [CNT_W-1:0] cnt_merged;
    logic [BUF_W-1:0] ext_item;
    logic [BUF_W-1:0] buf_merged;
    logic [GP_W-1:0]  gp_plus1;

    assign gp_plus1 = gp_reg + 3'd1;

    // append the new item to the buffer and work out the results
    always_comb begin
        if (pack_mode) begin
            cnt_clamp = (cnt_reg > PACK_CLAMP) ? PACK_CLAMP : cnt_reg;
            ext_item  = {16'b0, item[COEF_W-1:0]};
        end else begin
            cnt_clamp = (cnt_reg > UNPACK_CLAMP) ? UNPACK_CLAMP : cnt_reg;
            ext_item  = {14'b0, item[BYTE_W-1:0], item[WORD_W-1:BYTE_W]};
        end
        buf_merged = buf_reg | (ext_item << cnt_clamp);
        cnt_merged = cnt_clamp + (pack_mode ? COEF_BITS : WORD_BITS);

        res0 = '0;
        res1 = '0;
        if (pack_mode) begin
            // one word per full pair of bytes, earlier byte high
            res0.word = {buf_merged[BYTE_W-1:0], buf_merged[2*BYTE_W-1:BYTE_W]};
            res0.last = 1'b1;
            res0.gend = (gp_reg == GROUP_LAST);
            gp_next   = gp_plus1;
            if (cnt_merged >= WORD_BITS) begin
                res_count = 2'd1;
                buf_next  = buf_merged >> WORD_W;
                cnt_next  = cnt_merged - WORD_BITS;
            end else begin
                res_count = 2'd0;
                buf_next  = buf_merged;
                cnt_next  = cnt_merged;
            end
        end else begin
            // one or two coefficients, oldest bits first
            res0.word = {2'b0, buf_merged[COEF_W-1:0]};
            res0.gend = (gp_reg == GROUP_LAST);
            res1.word = {2'b0, buf_merged[2*COEF_W-1:COEF_W]};
            res1.last = 1'b1;
            res1.gend = (gp_plus1 == GROUP_LAST);
            if (cnt_merged >= TWO_COEF_BITS) begin
                res_count = 2'd2;
                res0.last = 1'b0;
                buf_next  = buf_merged >> (2 * COEF_W);
                cnt_next  = cnt_merged - TWO_COEF_BITS;
                gp_next   = gp_reg + 3'd2;
            end else begin
                res_count = 2'd1;
                res0.last = 1'b1;
                buf_next  = buf_merged >> COEF_W;
                cnt_next  = cnt_merged - COEF_BITS;
                gp_next   = gp_plus1;
            end
        end
    end

    // stream state
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            buf_reg <= '0;
            cnt_reg <= '0;
            gp_reg  <= '0;
        end else if (fire) begin
            buf_reg <= buf_next;
            cnt_reg <= cnt_next;
            gp_reg  <= gp_next;
        end
    end

endmodule

// File: rtl/core/coeff14_pack_unpack.sv
// An accepted request passes the input, multiply and fix-up registers and the
// result queue before its first result shows on m_. One input per cycle in
// pack mode while the receiver keeps up; in unpack mode the single result
// port limits input. The two-entry queue and bit buffer update set the rate.
// Reset: synchronous on aresetn low; mode returns to pack, buffer empties.
// ----------------------------------------------------------------------------
// coeff14_pack_unpack
// 14-bit coefficient packer and unpacker with a mode register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module coeff14_pack_unpack
    import c14pu_pkg::*;
#(
    parameter int MODULUS = MODULUS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration
    input  logic              cfg_we,
    input  logic              cfg_wdata,     // pack_mode
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [WORD_W-1:0] s_tdata,       // [15:0] in_word
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [WORD_W-1:0] m_tdata,       // [15:0] out_word
    output logic              m_tlast,       // run_last
    output logic              m_tuser        // [0] group_end
);

    logic              pack_mode_reg;
    logic              red_valid, red_ready;
    logic [WORD_W-1:0] red_data;
    logic              fire;
    logic [1:0]        res_count;
    c14pu_result_t     res0, res1;
    c14pu_result_t     q0_reg, q0_next, q1_reg, q1_next;
    logic [1:0]        count_reg, count_next, cnt_pop;
    logic              pop;
    logic              room;

    // mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pack_mode_reg <= 1'b1;
        end else if (cfg_we) begin
            pack_mode_reg <= cfg_wdata;
        end
    end

    // reduction pipeline
    c14pu_reduce #(
        .MODULUS (MODULUS)
    ) u_reduce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pack_mode (pack_mode_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (red_valid),
        .out_ready (red_ready),
        .out_data  (red_data)
    );

    // bit buffer
    c14pu_gearbox u_gearbox (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (cfg_we),
        .fire      (fire),
        .pack_mode (pack_mode_reg),
        .item      (red_data),
        .res_count (res_count),
        .res0      (res0),
        .res1      (res1)
    );

    // gearbox fires only when the queue can take all its results
    assign room      = ({1'b0, count_reg} + {1'b0, res_count}) <= 3'd2;
    assign red_ready = room;
    assign fire      = red_valid && room;
    assign pop       = m_tvalid && m_tready;

    // two-entry result queue
    always_comb begin
        cnt_pop = count_reg - {1'b0, pop};
        q0_next = pop ? q1_reg : q0_reg;
        q1_next = q1_reg;
        if (fire && res_count != 2'd0) begin
            if (cnt_pop == 2'd0) begin
                q0_next = res0;
            end else begin
                q1_next = res0;
            end
            if (res_count == 2'd2) begin
                q1_next = res1;
            end
        end
        count_next = cnt_pop + (fire ? res_count : 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = q0_reg.word;
    assign m_tlast  = q0_reg.last;
    assign m_tuser  = q0_reg.gend;

    // checks
    `C14_NEVER(a_queue_bound, aclk, aresetn, count_reg == 2'd3)
    `C14_ASSERT(a_pack_single, aclk, aresetn, fire && pack_mode_reg |-> res_count != 2'd2)
    `C14_ASSERT(a_result_shown, aclk, aresetn, fire && res_count != 2'd0 |=> m_tvalid)
    `C14_ASSERT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)

endmodule

// File: tb/sv/coeff14_pack_unpack_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coeff14_pack_unpack_tb
// Drives coefficient and word streams through both modes of the 14-bit
// packer, with random bursts, receiver stalls and two long receiver holds.
// A predictor tracks the bit buffer and group slot and checks every result.
// ----------------------------------------------------------------------------
module coeff14_pack_unpack_tb;
    import c14pu_pkg::*;

    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 150;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int RANDOM_WORDS  = 1526;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_BEAT} rx_style_t;

    logic              aclk;
    logic              aresetn   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic              cfg_wdata = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [WORD_W-1:0] s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [WORD_W-1:0] m_tdata;
    logic              m_tlast;
    logic              m_tuser;

    // input words waiting to be offered, results still owed by the block
    logic [WORD_W-1:0] words_to_send [$];
    c14pu_result_t     results_due [$];

    // predictor state
    logic              mdl_pack    = 1'b1;
    logic [BUF_W-1:0]  stream_bits = '0;
    logic [CNT_W-1:0]  stream_len  = '0;
    logic [GP_W-1:0]   slot        = '0;

    int        mismatches = 0;
    int        cycles     = 0;
    bit        took       = 1'b0;
    int        burst_left = 0;
    int        gap_left   = 0;
    bit        hold_arm   = 1'b0;
    int        hold_left  = 0;
    rx_style_t rx_style   = RX_ALWAYS;
    int        rx_left    = 0;
    int        rx_tick    = 0;

    // directed words: pack group plus a partial one, pack after clear, unpack
    logic [WORD_W-1:0] directed_words [24] = '{
        16'h0000, 16'hFFFF, 16'h3000, 16'h3001, 16'h3FFF, 16'h6001, 16'hAAAA,
        16'h5555, 16'h4000, 16'h6002, 16'h8000,
        16'h0001, 16'h7FFF, 16'hF004, 16'h3002,
        16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555, 16'h00FF, 16'hFF00, 16'h8001,
        16'h7FFE, 16'h1234
    };

    coeff14_pack_unpack i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // advance the gearbox by one accepted word and queue what it emits
    function automatic void gearbox_step(input logic [WORD_W-1:0] w);
        logic [31:0]       acc;
        logic [COEF_W-1:0] coef;
        logic [WORD_W-1:0] swapped;
        logic              closes_group;
        int                n;
        c14pu_result_t     r;
        if (mdl_pack) begin
            coef = COEF_W'(w % WORD_W'(MODULUS_DEF));
            closes_group = (slot == GROUP_LAST);
            slot = slot + 3'd1;
            if (stream_len > PACK_CLAMP) begin
                stream_len = PACK_CLAMP;
            end
            acc = {2'b00, stream_bits} | (32'(coef) << stream_len);
            stream_bits = acc[BUF_W-1:0];
            stream_len = stream_len + COEF_BITS;
            if (stream_len >= WORD_BITS) begin
                // earlier byte goes to the high half
                r.word = {stream_bits[7:0], stream_bits[15:8]};
                r.last = 1'b1;
                r.gend = closes_group;
                results_due.push_back(r);
                stream_bits = stream_bits >> WORD_BITS;
                stream_len = stream_len - WORD_BITS;
            end
        end else begin
            // high byte enters the stream first
            swapped = {w[7:0], w[15:8]};
            if (stream_len > UNPACK_CLAMP) begin
                stream_len = UNPACK_CLAMP;
            end
            acc = {2'b00, stream_bits} | (32'(swapped) << stream_len);
            stream_bits = acc[BUF_W-1:0];
            stream_len = stream_len + WORD_BITS;
            n = 0;
            while (stream_len >= COEF_BITS && n < 2) begin
                r.word = {2'b00, stream_bits[COEF_W-1:0]};
                r.gend = (slot == GROUP_LAST);
                slot = slot + 3'd1;
                stream_bits = stream_bits >> COEF_BITS;
                stream_len = stream_len - COEF_BITS;
                n++;
                r.last = !(stream_len >= COEF_BITS && n < 2);
                results_due.push_back(r);
            end
        end
    endfunction

    // wait until everything sent has come back, then let the pipe empty
    task automatic settle();
        while (words_to_send.size() != 0 || results_due.size() != 0 || s_tvalid) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // mode write while idle, clears the stream state
    task automatic write_mode(input logic pack);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= pack;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        mdl_pack    = pack;
        stream_bits = '0;
        stream_len  = '0;
        slot        = '0;
    endtask

    // stimulus sequence
    initial begin : stim
        int                budget;
        int                n;
        int                ph;
        int                k;
        logic              pack;
        logic [WORD_W-1:0] w;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // pack after reset, full group then a partial one
        for (int i = 0; i < 11; i++) begin
            words_to_send.push_back(directed_words[i]);
        end
        // rewrite of the same mode drops the partial group
        write_mode(1'b1);
        for (int i = 11; i < 15; i++) begin
            words_to_send.push_back(directed_words[i]);
        end
        write_mode(1'b0);
        for (int i = 15; i < 24; i++) begin
            words_to_send.push_back(directed_words[i]);
        end

        // random phases, mode picked per phase
        budget = RANDOM_WORDS;
        ph = 0;
        while (budget > 0) begin
            pack = (ph < 2) ? (ph == 0) : 1'($urandom_range(0, 1));
            write_mode(pack);
            if (ph < 2) begin
                hold_arm = 1'b1;
            end
            n = $urandom_range(100, 260);
            if (n > budget) begin
                n = budget;
            end
            for (int i = 0; i < n; i++) begin
                if (pack) begin
                    case ($urandom_range(0, 3))
                        0: w = 16'($urandom_range(0, 65535));
                        1: w = 16'($urandom_range(0, MODULUS_DEF - 1));
                        2: begin
                            // just around a multiple of the modulus
                            k = $urandom_range(1, 5);
                            w = 16'(k * MODULUS_DEF + $urandom_range(0, 2) - 1);
                        end
                        default: w = 16'($urandom_range(60000, 65535));
                    endcase
                end else begin
                    case ($urandom_range(0, 9))
                        0: w = 16'h0000;
                        1: w = 16'hFFFF;
                        default: w = 16'($urandom_range(0, 65535));
                    endcase
                end
                words_to_send.push_back(w);
            end
            budget -= n;
            ph++;
        end

        settle();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // sender: note accepted requests and feed the predictor
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            gearbox_step(s_tdata);
            void'(words_to_send.pop_front());
            took = 1'b1;
        end
    end

    // sender: bursts of offers with gaps, an offer holds until taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || took) begin
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                         : $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (words_to_send.size() > 0) begin
                burst_left--;
                s_tvalid <= 1'b1;
                s_tdata  <= words_to_send[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        took = 1'b0;
    end

    // long receiver hold, counted here
    always @(posedge aclk) begin
        if (hold_arm) begin
            hold_left = HOLD_CYCLES;
            hold_arm  = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
        end
    end

    // receiver: stall pattern switches style every so often
    always @(negedge aclk) begin : rx
        bit r;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_style = rx_style_t'($urandom_range(0, 3));
                rx_left  = $urandom_range(20, 200);
            end
            rx_left--;
            rx_tick++;
            case (rx_style)
                RX_ALWAYS: r = 1'b1;
                RX_COIN:   r = 1'($urandom_range(0, 1));
                RX_MOSTLY: r = ($urandom_range(0, 4) != 0);
                default:   r = ((rx_tick % 4) != 3);
            endcase
            m_tready <= r && (hold_left == 0);
        end
    end

    // result check against the oldest expectation
    always @(posedge aclk) begin : mon
        c14pu_result_t got;
        c14pu_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.word = m_tdata;
            got.last = m_tlast;
            got.gend = m_tuser;
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: word=%h last=%b gend=%b",
                             got.word, got.last, got.gend);
                end
            end else begin
                want = results_due.pop_front();
                if (got.word !== want.word || got.last !== want.last
                        || got.gend !== want.gend) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected word=%h last=%b gend=%b, got word=%h last=%b gend=%b",
                                 want.word, want.last, want.gend,
                                 got.word, got.last, got.gend);
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/c14pu_pkg.sv
rtl/core/c14pu_reduce.sv
rtl/core/c14pu_gearbox.sv
rtl/core/coeff14_pack_unpack.sv
tb/sv/coeff14_pack_unpack_tb.sv
